FILE: sv/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
`default_nettype none
package wsfd_pkg;

  localparam int LIMIT_BITS_DEF  = 24;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_W      = 25;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_MASK_REQ    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD = 1'd1;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam int         CTRL_MAX_LEN = 125;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_RESERVED  = 3'd0,
    ERR_LEN64_TOP = 3'd1,
    ERR_UNMASKED  = 3'd2,
    ERR_TOO_LONG  = 3'd3,
    ERR_FRAG_CTRL = 3'd4,
    ERR_BIG_CTRL  = 3'd5
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    err_t       code;
  } item_t;

endpackage
`default_nettype wire

FILE: sv/wsfd_front.sv
// Header parser: accepts bytes, tracks frame state, checks rules, queues result records.
`default_nettype none
module wsfd_front #(
  parameter int LIMIT_BITS = wsfd_pkg::LIMIT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [7:0]                      in_tdata,
  input  wire logic                            cfg_wr_en,
  input  wire logic [wsfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [wsfd_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                                 push,
  output wsfd_pkg::item_t                      item
);

  localparam int LEN_W = (LIMIT_BITS + 1 > wsfd_pkg::CFG_W) ? LIMIT_BITS + 1 : wsfd_pkg::CFG_W;
  localparam logic [LEN_W-1:0] CAP = LEN_W'(1) << LIMIT_BITS;
  localparam logic [LEN_W-1:0] CTRL_MAX = LEN_W'(wsfd_pkg::CTRL_MAX_LEN);

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         hdr0_r, hdr0_nxt;
  logic [LEN_W-1:0]   acc_r, acc_nxt;
  logic               acc_hi_r, acc_hi_nxt;
  logic               top_r, top_nxt;
  logic [3:0]         len_left_r, len_left_nxt;
  logic               mask_r, mask_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [1:0]         key_cnt_r, key_cnt_nxt;
  logic [LEN_W-1:0]   pay_left_r, pay_left_nxt;
  logic [1:0]         key_pos_r, key_pos_nxt;
  logic               err_r, err_nxt;
  logic               req_mask_r, req_mask_nxt;
  logic [LEN_W-1:0]   max_pay_r, max_pay_nxt;

  logic [LEN_W-1:0]   limit;
  logic               accept;

  assign limit  = (max_pay_r > CAP) ? CAP : max_pay_r;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    logic          do_after;
    logic          do_end;
    logic          fail;
    wsfd_pkg::err_t fail_code;
    logic [7:0]    kb;

    phase_nxt    = phase_r;
    hdr0_nxt     = hdr0_r;
    acc_nxt      = acc_r;
    acc_hi_nxt   = acc_hi_r;
    top_nxt      = top_r;
    len_left_nxt = len_left_r;
    mask_nxt     = mask_r;
    key_nxt      = key_r;
    key_cnt_nxt  = key_cnt_r;
    pay_left_nxt = pay_left_r;
    key_pos_nxt  = key_pos_r;
    err_nxt      = err_r;
    req_mask_nxt = req_mask_r;
    max_pay_nxt  = max_pay_r;
    do_after     = 1'b0;
    do_end       = 1'b0;
    fail         = 1'b0;
    fail_code    = wsfd_pkg::ERR_RESERVED;
    push         = 1'b0;
    kb           = 8'd0;

    item.kind   = wsfd_pkg::KIND_PAYLOAD;
    item.data   = in_tdata;
    item.key    = 8'd0;
    item.opcode = hdr0_r[3:0];
    item.fin    = hdr0_r[7];
    item.last   = 1'b0;
    item.code   = wsfd_pkg::ERR_RESERVED;

    if (cfg_wr_en) begin
      case (cfg_addr)
        wsfd_pkg::REG_MASK_REQ:    req_mask_nxt = cfg_wdata[0];
        wsfd_pkg::REG_MAX_PAYLOAD: max_pay_nxt  = LEN_W'(cfg_wdata);
        default: ;
      endcase
    end

    if (accept && !err_r) begin
      case (phase_r)
        PH_HDR1: begin
          if (hdr0_r[6:4] != 3'd0) begin
            fail      = 1'b1;
            fail_code = wsfd_pkg::ERR_RESERVED;
          end else begin
            mask_nxt   = in_tdata[7];
            acc_nxt    = '0;
            acc_hi_nxt = 1'b0;
            top_nxt    = 1'b0;
            if (in_tdata[6:0] == wsfd_pkg::LEN7_EXT16) begin
              len_left_nxt = 4'd2;
              phase_nxt    = PH_EXTLEN;
            end else if (in_tdata[6:0] == wsfd_pkg::LEN7_EXT64) begin
              len_left_nxt = 4'd8;
              phase_nxt    = PH_EXTLEN;
            end else begin
              acc_nxt  = LEN_W'(in_tdata[6:0]);
              do_after = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          acc_nxt    = {acc_r[LEN_W-9:0], in_tdata};
          acc_hi_nxt = acc_hi_r || (acc_r[LEN_W-1 -: 8] != 8'd0);
          if (len_left_r == 4'd8) begin
            top_nxt = in_tdata[7];
          end
          if (len_left_r != 4'd0) begin
            len_left_nxt = len_left_r - 4'd1;
          end
          if (len_left_nxt == 4'd0) begin
            if (top_nxt) begin
              fail      = 1'b1;
              fail_code = wsfd_pkg::ERR_LEN64_TOP;
            end else begin
              do_after = 1'b1;
            end
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], in_tdata};
          if (key_cnt_r != 2'd3) begin
            key_cnt_nxt = key_cnt_r + 2'd1;
          end else begin
            key_cnt_nxt = 2'd0;
            do_end      = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          case (key_pos_r)
            2'd0:    kb = key_r[31:24];
            2'd1:    kb = key_r[23:16];
            2'd2:    kb = key_r[15:8];
            default: kb = key_r[7:0];
          endcase
          key_pos_nxt = key_pos_r + 2'd1;
          if (pay_left_r != '0) begin
            pay_left_nxt = pay_left_r - LEN_W'(1);
          end
          push      = 1'b1;
          item.key  = kb;
          item.last = (pay_left_nxt == '0);
          if (pay_left_nxt == '0) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          hdr0_nxt  = in_tdata;
          phase_nxt = PH_HDR1;
        end
      endcase

      if (do_after) begin
        if (req_mask_r && !mask_nxt) begin
          fail      = 1'b1;
          fail_code = wsfd_pkg::ERR_UNMASKED;
        end else begin
          key_nxt     = 32'd0;
          key_cnt_nxt = 2'd0;
          if (mask_nxt) begin
            phase_nxt = PH_KEY;
          end else begin
            do_end = 1'b1;
          end
        end
      end

      if (do_end) begin
        if (acc_hi_nxt || (acc_nxt > limit)) begin
          fail      = 1'b1;
          fail_code = wsfd_pkg::ERR_TOO_LONG;
        end else if (hdr0_r[3] && !hdr0_r[7]) begin
          fail      = 1'b1;
          fail_code = wsfd_pkg::ERR_FRAG_CTRL;
        end else if (hdr0_r[3] && (acc_nxt > CTRL_MAX)) begin
          fail      = 1'b1;
          fail_code = wsfd_pkg::ERR_BIG_CTRL;
        end else if (acc_nxt == '0) begin
          push      = 1'b1;
          item.kind = wsfd_pkg::KIND_EMPTY;
          item.data = 8'd0;
          item.last = 1'b1;
          phase_nxt = PH_HDR0;
        end else begin
          pay_left_nxt = acc_nxt;
          key_pos_nxt  = 2'd0;
          phase_nxt    = PH_PAYLOAD;
        end
      end

      if (fail) begin
        err_nxt   = 1'b1;
        phase_nxt = PH_HDR0;
        push      = 1'b1;
        item.kind = wsfd_pkg::KIND_ERROR;
        item.data = 8'd0;
        item.key  = 8'd0;
        item.last = 1'b0;
        item.code = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      hdr0_r     <= 8'd0;
      acc_r      <= '0;
      acc_hi_r   <= 1'b0;
      top_r      <= 1'b0;
      len_left_r <= 4'd0;
      mask_r     <= 1'b0;
      key_r      <= 32'd0;
      key_cnt_r  <= 2'd0;
      pay_left_r <= '0;
      key_pos_r  <= 2'd0;
      err_r      <= 1'b0;
      req_mask_r <= 1'b1;
      max_pay_r  <= CAP;
    end else begin
      phase_r    <= phase_nxt;
      hdr0_r     <= hdr0_nxt;
      acc_r      <= acc_nxt;
      acc_hi_r   <= acc_hi_nxt;
      top_r      <= top_nxt;
      len_left_r <= len_left_nxt;
      mask_r     <= mask_nxt;
      key_r      <= key_nxt;
      key_cnt_r  <= key_cnt_nxt;
      pay_left_r <= pay_left_nxt;
      key_pos_r  <= key_pos_nxt;
      err_r      <= err_nxt;
      req_mask_r <= req_mask_nxt;
      max_pay_r  <= max_pay_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/wsfd_queue.sv
// Small FIFO of result records between the parser and the output stage.
`default_nettype none
module wsfd_queue #(
  parameter int DEPTH = wsfd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire wsfd_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output wsfd_pkg::item_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsfd_pkg::item_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: sv/wsfd_back.sv
// Output stage: unmasks payload bytes and holds the result transaction for the receiver.
`default_nettype none
module wsfd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire wsfd_pkg::item_t q_head,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [15:0]          out_tdata,
  output logic                 out_tlast,
  output logic [1:0]           out_tuser
);

  logic        valid_r, valid_nxt;
  logic [15:0] data_r;
  logic        last_r;
  logic [1:0]  user_r;

  assign q_pop     = q_valid && (!valid_r || out_tready);
  assign valid_nxt = q_pop || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= {q_head.code, q_head.fin, q_head.opcode, q_head.data ^ q_head.key};
      last_r <= q_head.last;
      user_r <= q_head.kind;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;

endmodule
`default_nettype wire

FILE: sv/websocket_frame_decoder_top.sv
// Top level of the WebSocket frame decoder.
//
// Input stream: one received byte per transaction on in_tdata. Result stream:
// one transaction per payload byte (unmasked), one per zero-length frame, and
// one for the first protocol error; out_tuser gives the kind, out_tlast marks
// the last result of a frame. Header bytes and mask key bytes give no result.
// Throughput: one byte per cycle while the queue has room, sustained with back-to-back transactions.
// A result is written to the queue at the edge that takes its byte, and from
// there into the output register that drives out_tvalid.
// The queue of QUEUE_DEPTH records lets the parser keep taking bytes while the
// receiver stalls; in_tready drops once the queue is full.
// After an error the block drops every byte without result until reset.
// Reset (rst_n low, synchronous) clears parser state, empties the queue, turns
// the mask requirement on and sets max_payload to 2**LIMIT_BITS.
// Configuration: cfg_wr_en with cfg_addr 0 writes the mask-required flag, 1
// writes max_payload; write only while the block is idle.
`default_nettype none
module websocket_frame_decoder_top #(
  parameter int LIMIT_BITS  = wsfd_pkg::LIMIT_BITS_DEF,
  parameter int QUEUE_DEPTH = wsfd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] data_byte
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [7:0] payload_byte, [11:8] opcode, [12] fin, [15:13] error_code
  output logic [15:0]                          out_tdata,
  output logic                                 out_tlast,
  output logic [1:0]                           out_tuser,  // [1:0] kind
  input  wire logic                            cfg_wr_en,
  input  wire logic [wsfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [wsfd_pkg::CFG_W-1:0]      cfg_wdata
);

  logic            push;
  wsfd_pkg::item_t push_item;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  wsfd_pkg::item_t q_head;

  assign in_tready = !q_full;

  wsfd_front #(
    .LIMIT_BITS (LIMIT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .item      (push_item)
  );

  wsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  wsfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_error_is_final : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (out_tuser == wsfd_pkg::KIND_ERROR) |=> !out_tvalid)
    else $error("result after error transaction");

  a_error_not_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wsfd_pkg::KIND_ERROR) |-> !out_tlast)
    else $error("error transaction marked last");

  a_empty_frame : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wsfd_pkg::KIND_EMPTY) |->
      out_tlast && (out_tdata[7:0] == 8'd0) && (out_tdata[15:13] == 3'd0))
    else $error("malformed empty frame transaction");

endmodule
`default_nettype wire

FILE: tb/sv/frame_decode_checker.sv
// Checker for the frame decoder: tracks config, predicts every result and compares the outputs.
module frame_decode_checker
  import wsfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [15:0]           out_tdata,
  input  logic                  out_tlast,
  input  logic [1:0]            out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    bad_results,
  output int                    in_flight
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] pbyte;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    err_t       code;
  } result_t;

  localparam logic [7:0]  RSV_BITS        = 8'h70;
  localparam logic [3:0]  CTRL_OPCODE_MIN = 4'h8;
  localparam logic [3:0]  EXT16_BYTES     = 4'd2;
  localparam logic [3:0]  EXT64_BYTES     = 4'd8;
  localparam logic [1:0]  KEY_LAST        = 2'd3;
  localparam logic [63:0] LEN_CAP         = 64'd1 << LIMIT_BITS_DEF;
  localparam int          SHOW_LIMIT      = 10;

  result_t decoded_q[$];

  logic             req_mask;
  logic [CFG_W-1:0] max_len;
  phase_t           phase;
  logic [7:0]       hdr0;
  logic [63:0]      len_acc;
  logic [3:0]       len_left;
  logic             masked;
  logic [31:0]      key;
  logic [1:0]       key_cnt;
  logic [24:0]      left;
  logic [1:0]       key_pos;
  logic             stuck;

  function automatic void push_result(kind_t k, logic [7:0] pb, logic last, err_t code);
    result_t r;
    r.kind   = k;
    r.pbyte  = pb;
    r.opcode = hdr0[3:0];
    r.fin    = hdr0[7];
    r.last   = last;
    r.code   = code;
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  function automatic void latch_error(err_t code);
    stuck = 1'b1;
    phase = PH_HDR0;
    push_result(KIND_ERROR, 8'h00, 1'b0, code);
  endfunction

  function automatic void close_header();
    logic [63:0] lim;
    lim = (64'(max_len) > LEN_CAP) ? LEN_CAP : 64'(max_len);
    if (len_acc > lim) begin
      latch_error(ERR_TOO_LONG);
    end else if (hdr0[3:0] >= CTRL_OPCODE_MIN && !hdr0[7]) begin
      latch_error(ERR_FRAG_CTRL);
    end else if (hdr0[3:0] >= CTRL_OPCODE_MIN && len_acc > 64'(CTRL_MAX_LEN)) begin
      latch_error(ERR_BIG_CTRL);
    end else if (len_acc == 64'd0) begin
      phase = PH_HDR0;
      push_result(KIND_EMPTY, 8'h00, 1'b1, ERR_RESERVED);
    end else begin
      left    = len_acc[24:0];
      key_pos = 2'd0;
      phase   = PH_PAYLOAD;
    end
  endfunction

  function automatic void close_length();
    if (req_mask && !masked) begin
      latch_error(ERR_UNMASKED);
    end else begin
      key     = '0;
      key_cnt = '0;
      if (masked) phase = PH_KEY;
      else close_header();
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [7:0] kb;
    if (stuck) return;
    case (phase)
      PH_HDR1: begin
        if ((hdr0 & RSV_BITS) != 8'h00) begin
          latch_error(ERR_RESERVED);
        end else begin
          masked  = b[7];
          len_acc = '0;
          if (b[6:0] == LEN7_EXT16) begin
            len_left = EXT16_BYTES;
            phase    = PH_EXTLEN;
          end else if (b[6:0] == LEN7_EXT64) begin
            len_left = EXT64_BYTES;
            phase    = PH_EXTLEN;
          end else begin
            len_acc = 64'(b[6:0]);
            close_length();
          end
        end
      end
      PH_EXTLEN: begin
        len_acc = {len_acc[55:0], b};
        if (len_left != 4'd0) len_left--;
        if (len_left == 4'd0) begin
          if (len_acc[63]) latch_error(ERR_LEN64_TOP);
          else close_length();
        end
      end
      PH_KEY: begin
        key = {key[23:0], b};
        if (key_cnt != KEY_LAST) begin
          key_cnt++;
        end else begin
          key_cnt = 2'd0;
          close_header();
        end
      end
      PH_PAYLOAD: begin
        kb = key[8*(3-key_pos) +: 8];
        key_pos++;
        if (left != 25'd0) left--;
        if (left == 25'd0) phase = PH_HDR0;
        push_result(KIND_PAYLOAD, b ^ kb, left == 25'd0, ERR_RESERVED);
      end
      default: begin
        hdr0  = b;
        phase = PH_HDR1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      req_mask    = 1'b1;
      max_len     = CFG_W'(1) << LIMIT_BITS_DEF;
      phase       = PH_HDR0;
      hdr0        = '0;
      len_acc     = '0;
      len_left    = '0;
      masked      = 1'b0;
      key         = '0;
      key_cnt     = '0;
      left        = '0;
      key_pos     = '0;
      stuck       = 1'b0;
      bad_results = 0;
      decoded_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == REG_MASK_REQ) req_mask = cfg_wdata[0];
        else if (cfg_addr == REG_MAX_PAYLOAD) max_len = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        got.kind   = kind_t'(out_tuser);
        got.pbyte  = out_tdata[7:0];
        got.opcode = out_tdata[11:8];
        got.fin    = out_tdata[12];
        got.last   = out_tlast;
        got.code   = err_t'(out_tdata[15:13]);
        if (decoded_q.size() == 0) begin
          bad_results++;
          if (bad_results <= SHOW_LIMIT)
            $display({"%0t: result with nothing pending: kind %0d byte %02h op %0h",
                      " fin %0b last %0b err %0d"}, $realtime,
                     got.kind, got.pbyte, got.opcode, got.fin, got.last, got.code);
        end else begin
          want = decoded_q.pop_front();
          if (got.kind !== want.kind || got.pbyte !== want.pbyte || got.opcode !== want.opcode ||
              got.fin !== want.fin || got.last !== want.last || got.code !== want.code) begin
            bad_results++;
            if (bad_results <= SHOW_LIMIT)
              $display({"%0t: mismatch exp/got: kind %0d/%0d byte %02h/%02h op %0h/%0h",
                        " fin %0b/%0b last %0b/%0b err %0d/%0d"}, $realtime,
                       want.kind, got.kind, want.pbyte, got.pbyte, want.opcode, got.opcode,
                       want.fin, got.fin, want.last, got.last, want.code, got.code);
          end
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata);
    end
    in_flight <= decoded_q.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Testbench top: clock, reset, frame stimulus, receiver stalls, watchdog and verdict.
module testbench;
  import wsfd_pkg::*;

  typedef enum int {
    ENC_SHORT,
    ENC_EXT16,
    ENC_EXT64
  } len_enc_t;

  localparam int               WATCHDOG_LIMIT  = 4000;
  localparam int               RX_HOLD_CYCLES  = 80;
  localparam int               SETTLE_CYCLES   = 4;
  localparam int               SHORT_FRAME_MAX = 12;
  localparam int               LONG_FRAME_MAX  = 130;
  localparam logic [CFG_W-1:0] MAX_LEN_CAP     = 25'h1000000;
  localparam logic [CFG_W-1:0] MAX_LEN_ALL     = 25'h1FFFFFF;
  localparam logic [3:0]       OPC_CONT        = 4'h0;
  localparam logic [3:0]       OPC_TEXT        = 4'h1;
  localparam logic [3:0]       OPC_BIN         = 4'h2;
  localparam logic [3:0]       OPC_DATA_RSV    = 4'h3;
  localparam logic [3:0]       OPC_DATA_LAST   = 4'h7;
  localparam logic [3:0]       OPC_CLOSE       = 4'h8;
  localparam logic [3:0]       OPC_PING        = 4'h9;
  localparam logic [3:0]       OPC_PONG        = 4'hA;
  localparam logic [3:0]       OPC_CTRL_LAST   = 4'hF;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [7:0]            in_tdata   = 8'h00;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = REG_MASK_REQ;
  logic [CFG_W-1:0]      cfg_wdata  = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [15:0]           out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;

  int bad_results;
  int in_flight;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int stall_cycles = 0;
  int sent         = 0;

  logic             cur_req = 1'b1;
  logic [CFG_W-1:0] cur_max = MAX_LEN_CAP;

  always #10 clk = ~clk;

  websocket_frame_decoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  frame_decode_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .bad_results (bad_results),
    .in_flight   (in_flight)
  );

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = RX_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic mask_on, input logic [63:0] len, input len_enc_t enc,
                            input bit hdr_only, input bit extremes);
    logic [31:0]     k;
    len_enc_t        e;
    longint unsigned n;
    int              i;
    k = $urandom;
    e = enc;
    if (len >= 64'(LEN7_EXT16) && e == ENC_SHORT) e = ENC_EXT16;
    send_byte({fin, rsv, op});
    case (e)
      ENC_SHORT: send_byte({mask_on, len[6:0]});
      ENC_EXT16: begin
        send_byte({mask_on, LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask_on, LEN7_EXT64});
        for (i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (mask_on)
      for (i = 3; i >= 0; i--) send_byte(k[8*i +: 8]);
    if (!hdr_only)
      for (n = 0; n < len; n++)
        send_byte(extremes ? (n[0] ? 8'hFF : 8'h00) : 8'($urandom));
  endtask

  task automatic send_random_frame();
    logic [63:0] lim;
    logic [63:0] len;
    logic [3:0]  op;
    logic        fin;
    logic        mask_on;
    int          pick;
    int          hi;
    lim = (cur_max > MAX_LEN_CAP) ? 64'(MAX_LEN_CAP) : 64'(cur_max);
    if ($urandom_range(5) == 0) begin
      op  = 4'($urandom_range(OPC_CLOSE, OPC_CTRL_LAST));
      fin = 1'b1;
      if (lim > 64'(CTRL_MAX_LEN)) lim = 64'(CTRL_MAX_LEN);
    end else begin
      op  = 4'($urandom_range(OPC_CONT, OPC_DATA_LAST));
      fin = 1'($urandom_range(1));
    end
    pick = $urandom_range(15);
    if (pick == 0 || lim == 64'd0) begin
      len = 64'd0;
    end else begin
      hi  = (pick == 1) ? LONG_FRAME_MAX : SHORT_FRAME_MAX;
      if (lim < 64'(hi)) hi = int'(lim);
      len = 64'($urandom_range(1, hi));
    end
    mask_on = cur_req | 1'($urandom_range(1));
    send_frame(fin, 3'b000, op, mask_on, len, len_enc_t'($urandom_range(ENC_EXT64)), 1'b0, 1'b0);
  endtask

  task automatic run_frames(input int bytes);
    int stop_at;
    stop_at = sent + bytes;
    while (sent < stop_at) send_random_frame();
  endtask

  // wait for every pending result, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic req, input logic [CFG_W-1:0] maxv);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_MASK_REQ;
    cfg_wdata <= CFG_W'(req);
    @(posedge clk);
    cfg_addr  <= REG_MAX_PAYLOAD;
    cfg_wdata <= maxv;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_req = req;
    cur_max = maxv;
  endtask

  initial begin
    err_t which;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 29;
    rx_idle_pct = 57;
    set_config(1'b1, MAX_LEN_CAP);
    send_frame(1'b1, 3'b000, OPC_TEXT, 1'b1, 64'd4, ENC_SHORT, 1'b0, 1'b1);
    send_frame(1'b1, 3'b000, OPC_BIN, 1'b1, 64'd0, ENC_SHORT, 1'b0, 1'b0);
    send_frame(1'b1, 3'b000, OPC_PING, 1'b1, 64'd0, ENC_SHORT, 1'b0, 1'b0);
    send_frame(1'b1, 3'b000, OPC_CLOSE, 1'b1, 64'd2, ENC_EXT16, 1'b0, 1'b0);
    send_frame(1'b0, 3'b000, OPC_CONT, 1'b1, 64'd3, ENC_EXT64, 1'b0, 1'b0);
    send_frame(1'b1, 3'b000, OPC_DATA_RSV, 1'b1, 64'd1, ENC_SHORT, 1'b0, 1'b1);
    settle();

    // unmasked traffic allowed, length right at the limit
    set_config(1'b0, 25'd3);
    send_frame(1'b1, 3'b000, OPC_TEXT, 1'b0, 64'd3, ENC_SHORT, 1'b0, 1'b1);
    send_frame(1'b1, 3'b000, OPC_BIN, 1'b1, 64'd2, ENC_EXT64, 1'b0, 1'b0);
    send_frame(1'b1, 3'b000, OPC_PONG, 1'b0, 64'd0, ENC_SHORT, 1'b0, 1'b0);
    settle();

    set_config(1'b1, MAX_LEN_CAP);
    run_frames(500);
    settle();

    set_config(1'b1, '0);
    run_frames(60);
    settle();

    tx_idle_pct = 57;
    rx_idle_pct = 29;
    set_config(1'b0, MAX_LEN_ALL);
    run_frames(450);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(1'b0, 25'd20);
    hold_req++;
    run_frames(450);
    settle();

    // one protocol error, then the block must stay silent
    set_config(1'b1, MAX_LEN_ALL);
    which = err_t'($urandom_range(ERR_RESERVED, ERR_BIG_CTRL));
    case (which)
      ERR_RESERVED:
        send_frame(1'b1, 3'($urandom_range(1, 7)), OPC_TEXT, 1'b1, 64'd5, ENC_SHORT, 1'b0, 1'b0);
      ERR_LEN64_TOP:
        send_frame(1'b1, 3'b000, OPC_BIN, 1'b1, {1'b1, 63'($urandom)}, ENC_EXT64, 1'b1, 1'b0);
      ERR_UNMASKED:
        send_frame(1'b1, 3'b000, OPC_TEXT, 1'b0, 64'd3, ENC_SHORT, 1'b0, 1'b0);
      ERR_TOO_LONG:
        send_frame(1'b1, 3'b000, OPC_BIN, 1'b1, 64'(MAX_LEN_CAP) + 64'd1, ENC_EXT64, 1'b1,
                   1'b0);
      ERR_FRAG_CTRL:
        send_frame(1'b0, 3'b000, 4'($urandom_range(OPC_CLOSE, OPC_CTRL_LAST)), 1'b1, 64'd2,
                   ENC_SHORT, 1'b0, 1'b0);
      default:
        send_frame(1'b1, 3'b000, OPC_PING, 1'b1, 64'($urandom_range(126, 200)), ENC_EXT16,
                   1'b1, 1'b0);
    endcase
    run_frames(60);
    settle();

    if (bad_results == 0 && in_flight == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
